FILE: hdl/ust_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 sanitise and truncate unit.
package ust_pkg;

  localparam int          MAX_DATA   = 6;        // data bytes one item can cause
  localparam int          QDEPTH     = 2;
  localparam int          ADDR_W     = 3;
  localparam logic        REG_OUT_CAPACITY = 1'b0;  // register index, paddr[2]
  localparam logic [15:0] CAP_RESET  = 16'd128;

  localparam logic [7:0]  REPL_B0    = 8'hEF;
  localparam logic [7:0]  REPL_B1    = 8'hBF;
  localparam logic [7:0]  REPL_B2    = 8'hBD;

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] MIN_2      = 21'h000080;
  localparam logic [20:0] MIN_3      = 21'h000800;
  localparam logic [20:0] MIN_4      = 21'h010000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_has_byte;
    logic       in_last;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_string_end;
    logic       out_truncated;
  } res_item_t;

  // Per-string decoder state.
  typedef struct packed {
    logic [23:0] pb;
    logic [2:0]  pe;
    logic [1:0]  pc;
    logic [15:0] wc;
    logic        stopped;
  } fe_state_t;

  // Work handed from front to back: the bytes of one item.
  typedef struct packed {
    logic [MAX_DATA-1:0][7:0] data;
    logic [2:0]               nd;
    logic                     term;
    logic                     trunc;
  } run_t;

  typedef struct packed {
    fe_state_t s;
    run_t      d;
  } fe_work_t;

endpackage

FILE: hdl/utf8_sanitize_truncate_unit.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 sanitise and truncate unit.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  source    | push / full           | src_item: in_byte, in_has_byte, in_last
//  result    | empty / pop           | res_item: out_byte, out_run_last,
//            |                       |           out_string_end, out_truncated
//  config    | psel penable pwrite   | paddr, pwdata, prdata; out_capacity at 0
//
// The front decodes one item per cycle while the two-run queue has room.
// The back sends one result byte per cycle while pop is high; an item has up to
// 7 results, and items with no result use the front only.
// Reset clears all string state and sets out_capacity to 128.
// A stalled result side fills the queue, then raises full.
module utf8_sanitize_truncate_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ust_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  ust_pkg::src_item_t         src_item,
  output logic                       empty,
  input  logic                       pop,
  output ust_pkg::res_item_t         res_item
);
  import ust_pkg::*;

  logic take;
  logic enq;
  run_t fe_run;
  run_t q_data;
  logic q_valid;
  logic q_rd;

  assign pready = 1'b1;
  assign take   = push && !full;

  ust_front u_front (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .take    (take),
    .item    (src_item),
    .enq     (enq),
    .run     (fe_run)
  );

  ust_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq),
    .wr_data (fe_run),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .valid   (q_valid)
  );

  ust_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .res_item (res_item)
  );

endmodule

FILE: hdl/ust_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of runs between the front and back parts.
module ust_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ust_pkg::run_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output ust_pkg::run_t rd_data,
  output logic          valid
);
  import ust_pkg::*;

  run_t                        mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0]   wr_ptr;
  logic [$clog2(QDEPTH)-1:0]   rd_ptr;
  logic [$clog2(QDEPTH+1)-1:0] count;

  assign full    = (count == ($clog2(QDEPTH+1))'(QDEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == ($clog2(QDEPTH))'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == ($clog2(QDEPTH))'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(wr_en && full && !rd_en))
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) !(rd_en && !valid))
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst)
                   count <= ($clog2(QDEPTH+1))'(QDEPTH))
    else $error("queue count overflow");

endmodule

FILE: hdl/ust_front.sv
`timescale 1ns / 1ps
// Front part: capacity register, UTF-8 decode, capacity check; one item per take.
module ust_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ust_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  input  logic                       take,
  input  ust_pkg::src_item_t         item,
  output logic                       enq,
  output ust_pkg::run_t              run
);
  import ust_pkg::*;

  logic [15:0] cap;
  fe_state_t   st;
  fe_work_t    w;
  logic [7:0]  b;

  function automatic fe_work_t clear_pend(input fe_work_t x);
    fe_work_t r;
    r      = x;
    r.s.pb = '0;
    r.s.pe = '0;
    r.s.pc = '0;
    return r;
  endfunction

  // Emit a whole unit, or stop the string if it does not fit.
  function automatic fe_work_t emit_unit(input fe_work_t x, input logic [15:0] c,
                                         input logic [2:0] len,
                                         input logic [3:0][7:0] bytes);
    fe_work_t    r;
    logic [15:0] capm1;
    logic [15:0] room;
    logic [2:0]  idx;
    r = x;
    if (!x.s.stopped) begin
      capm1 = (c == 16'd0) ? 16'd0 : c - 16'd1;
      room  = (capm1 > x.s.wc) ? capm1 - x.s.wc : 16'd0;
      if ({13'd0, len} > room) begin
        r           = clear_pend(r);
        r.s.stopped = 1'b1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          idx = x.d.nd + 3'(i);
          if ((3'(i) < len) && (idx < 3'(MAX_DATA))) begin
            r.d.data[idx] = bytes[i];
          end
        end
        r.d.nd = x.d.nd + len;
        r.s.wc = x.s.wc + {13'd0, len};
      end
    end
    return r;
  endfunction

  function automatic fe_work_t emit_repl(input fe_work_t x, input logic [15:0] c);
    return emit_unit(x, c, 3'd3, {8'h00, REPL_B2, REPL_B1, REPL_B0});
  endfunction

  function automatic fe_work_t start_seq(input fe_work_t x, input logic [7:0] v,
                                         input logic [15:0] c);
    fe_work_t r;
    r = x;
    if (v[7] == 1'b0) begin
      r = emit_unit(x, c, 3'd1, {24'h0, v});
    end else if (v[7:5] == 3'b110 || v[7:4] == 4'b1110 || v[7:3] == 5'b11110) begin
      r.s.pe = (v[7:5] == 3'b110) ? 3'd2 : (v[7:4] == 4'b1110) ? 3'd3 : 3'd4;
      r.s.pb = {v, 16'h0};
      r.s.pc = '0;
    end else begin
      r = emit_repl(x, c);
    end
    return r;
  endfunction

  function automatic fe_work_t finish_seq(input fe_work_t x, input logic [7:0] v,
                                          input logic [15:0] c);
    fe_work_t        r;
    logic [3:0][7:0] seq;
    logic [20:0]     cp;
    logic [20:0]     lo;
    logic [2:0]      n;
    logic            ok;
    n      = x.s.pe;
    seq[0] = x.s.pb[23:16];
    seq[1] = x.s.pb[15:8];
    seq[2] = x.s.pb[7:0];
    seq[3] = 8'h00;
    seq[n[1:0] - 2'd1] = v;
    unique case (n)
      3'd2: begin
        cp = {10'd0, seq[0][4:0], seq[1][5:0]};
        lo = MIN_2;
      end
      3'd3: begin
        cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
        lo = MIN_3;
      end
      default: begin
        cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
        lo = MIN_4;
      end
    endcase
    ok = (cp >= lo) && (cp <= CP_MAX) && !((cp >= SURR_LO) && (cp <= SURR_HI));
    r  = clear_pend(x);
    if (ok) begin
      r = emit_unit(r, c, n, seq);
    end else begin
      r = emit_repl(r, c);
    end
    return r;
  endfunction

  assign b = item.in_byte;

  always_comb begin
    w.s = st;
    w.d = '0;
    if (item.in_has_byte && !w.s.stopped) begin
      if (w.s.pe != 3'd0) begin
        if (b[7:6] == 2'b10) begin
          if (({1'b0, w.s.pc} + 3'd2) == w.s.pe) begin
            w = finish_seq(w, b, cap);
          end else begin
            w.s.pc = w.s.pc + 2'd1;
            if (w.s.pc == 2'd1) begin
              w.s.pb[15:8] = b;
            end else begin
              w.s.pb[7:0] = b;
            end
          end
        end else begin
          // interrupted sequence: one replacement, then restart on this byte
          w = clear_pend(w);
          w = emit_repl(w, cap);
          if (!w.s.stopped) begin
            w = start_seq(w, b, cap);
          end
        end
      end else begin
        w = start_seq(w, b, cap);
      end
    end
    if (item.in_last) begin
      if (!w.s.stopped && w.s.pe != 3'd0) begin
        w = clear_pend(w);
        w = emit_repl(w, cap);
      end
      w.d.term    = 1'b1;
      w.d.trunc   = w.s.stopped;
      w           = clear_pend(w);
      w.s.wc      = '0;
      w.s.stopped = 1'b0;
    end
  end

  assign run    = w.d;
  assign enq    = take && ((w.d.nd != 3'd0) || w.d.term);
  assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? {16'd0, cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
      st  <= '0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_OUT_CAPACITY) begin
        cap <= pwdata[15:0];
      end
      if (take) begin
        st <= w.s;
      end
    end
  end

endmodule

FILE: hdl/ust_back.sv
`timescale 1ns / 1ps
// Back part: plays out each run onto the result ports, one byte per pop.
module ust_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ust_pkg::run_t      q_data,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output ust_pkg::res_item_t res_item
);
  import ust_pkg::*;

  run_t       cur;
  logic       busy;
  logic [2:0] idx;
  logic [2:0] total;
  logic       is_last;
  logic       at_term;

  assign total   = cur.nd + {2'b00, cur.term};
  assign is_last = (idx == total - 3'd1);
  assign at_term = (idx == cur.nd);
  assign empty   = !busy;
  assign q_rd    = q_valid && (!busy || (pop && is_last));

  always_comb begin
    res_item.out_byte       = 8'h00;
    if (!at_term && idx < 3'(MAX_DATA)) begin
      res_item.out_byte     = cur.data[idx];
    end
    res_item.out_run_last   = is_last;
    res_item.out_string_end = at_term;
    res_item.out_truncated  = at_term && cur.trunc;
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_rd) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && pop) begin
      if (is_last) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> (total != 3'd0))
    else $error("empty run loaded");
  assert property (@(posedge clk) disable iff (rst) busy |-> (idx < total))
    else $error("byte index past end of run");
  assert property (@(posedge clk) disable iff (rst)
                   (busy && pop && !is_last) |=> (busy && idx == $past(idx) + 3'd1))
    else $error("run did not advance");
  assert property (@(posedge clk) disable iff (rst)
                   (busy && !pop) |=> (busy && $stable(idx)))
    else $error("stalled run moved");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the UTF-8 sanitise and truncate unit: directed strings and random traffic.
module tb_top;
  import ust_pkg::*;

  localparam int STALL_LIMIT = 4000;   // cycles with no item moving on any port
  localparam int SETTLE      = 12;     // quiet margin after the last result
  localparam int MAX_PRINT   = 40;
  localparam logic [ADDR_W-1:0] CAP_ADDR = {REG_OUT_CAPACITY, 2'b00};

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push     = 1'b0;
  logic              full;
  src_item_t         src_item = '0;
  logic              empty;
  logic              pop      = 1'b0;
  res_item_t         res_item;

  utf8_sanitize_truncate_unit dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .src_item (src_item),
    .empty    (empty),
    .pop      (pop),
    .res_item (res_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sanitiser state as the block should hold it
  logic [15:0] cap_now  = CAP_RESET;
  logic [23:0] lead_buf = '0;     // lead 23:16, first continuation 15:8, second 7:0
  logic [2:0]  seq_len  = '0;     // 0: no sequence open
  logic [1:0]  cont_cnt = '0;
  logic [15:0] out_len  = '0;     // bytes written for this string
  logic        cut_off  = 1'b0;   // string has run out of room
  res_item_t   item_bytes[$];
  res_item_t   bytes_due[$];

  int n_mismatch   = 0;
  int n_sent       = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req_id  = 0;
  int hold_req_len = 0;
  int hold_seen_id = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  function automatic int room_left_now();
    int c;
    c = (cap_now == 16'd0) ? 1 : int'(cap_now);
    return (c - 1 > int'(out_len)) ? c - 1 - int'(out_len) : 0;
  endfunction

  function automatic void drop_seq();
    lead_buf = '0;
    seq_len  = '0;
    cont_cnt = '0;
  endfunction

  // a unit goes out whole, or stops the string if it does not fit
  function automatic void emit_whole(input logic [3:0][7:0] b, input int n);
    res_item_t r;
    int i;
    if (cut_off) return;
    if (n > room_left_now()) begin
      cut_off = 1'b1;
      drop_seq();
      return;
    end
    for (i = 0; i < n; i++) begin
      r = '{out_byte: b[i], out_run_last: 1'b0, out_string_end: 1'b0, out_truncated: 1'b0};
      item_bytes.push_back(r);
    end
    out_len = out_len + 16'(n);
  endfunction

  function automatic void emit_fffd();
    emit_whole({8'h00, REPL_B2, REPL_B1, REPL_B0}, 3);
  endfunction

  function automatic void open_seq(input logic [7:0] b);
    if (b < 8'h80) emit_whole({24'h0, b}, 1);
    else if (b >= 8'hC0 && b <= 8'hDF) seq_len = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) seq_len = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF7) seq_len = 3'd4;
    else begin
      emit_fffd();
      return;
    end
    if (seq_len != 3'd0) begin
      lead_buf = {b, 16'h0};
      cont_cnt = '0;
    end
  endfunction

  function automatic void close_seq(input logic [7:0] last_b);
    logic [3:0][7:0] s;
    int n, cp, lo, i;
    n = int'(seq_len);
    s = {8'h00, lead_buf[7:0], lead_buf[15:8], lead_buf[23:16]};
    s[n-1] = last_b;
    if (n == 2) begin
      cp = int'(s[0][4:0]);
      lo = int'(MIN_2);
    end else if (n == 3) begin
      cp = int'(s[0][3:0]);
      lo = int'(MIN_3);
    end else begin
      cp = int'(s[0][2:0]);
      lo = int'(MIN_4);
    end
    for (i = 1; i < n; i++) cp = (cp << 6) | int'(s[i][5:0]);
    drop_seq();
    if (cp >= lo && cp <= int'(CP_MAX) && !(cp >= int'(SURR_LO) && cp <= int'(SURR_HI)))
      emit_whole(s, n);
    else
      emit_fffd();
  endfunction

  function automatic void feed_byte(input logic [7:0] b);
    if (cut_off) return;
    if (seq_len != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        if (int'(cont_cnt) + 2 == int'(seq_len)) close_seq(b);
        else begin
          cont_cnt = cont_cnt + 2'd1;
          if (cont_cnt == 2'd1) lead_buf[15:8] = b;
          else lead_buf[7:0] = b;
        end
        return;
      end
      // interrupted: the open sequence becomes one replacement
      drop_seq();
      emit_fffd();
      if (cut_off) return;
    end
    open_seq(b);
  endfunction

  function automatic void sanitize_item(input src_item_t it);
    res_item_t t;
    item_bytes.delete();
    if (it.in_has_byte) feed_byte(it.in_byte);
    if (it.in_last) begin
      if (!cut_off && seq_len != 3'd0) begin
        drop_seq();
        emit_fffd();
      end
      t = '{out_byte: 8'h00, out_run_last: 1'b0, out_string_end: 1'b1, out_truncated: cut_off};
      item_bytes.push_back(t);
      drop_seq();
      out_len = '0;
      cut_off = 1'b0;
    end
    if (item_bytes.size() != 0) item_bytes[item_bytes.size()-1].out_run_last = 1'b1;
    foreach (item_bytes[k]) bytes_due.push_back(item_bytes[k]);
  endfunction

  function automatic src_item_t item_of(input logic [7:0] b, input logic has, input logic last);
    return '{in_byte: b, in_has_byte: has, in_last: last};
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (n_mismatch < MAX_PRINT)
      $display("%0t mismatch on %s: got %02h, want %02h", $realtime, what, got, want);
    n_mismatch++;
  endtask

  task automatic check_result(input res_item_t got);
    res_item_t want;
    if (bytes_due.size() == 0) begin
      report_mismatch("unexpected item", got.out_byte, 8'h00);
      return;
    end
    want = bytes_due.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", got.out_byte, want.out_byte);
    if (got.out_run_last !== want.out_run_last)
      report_mismatch("out_run_last", got.out_run_last, want.out_run_last);
    if (got.out_string_end !== want.out_string_end)
      report_mismatch("out_string_end", got.out_string_end, want.out_string_end);
    if (got.out_truncated !== want.out_truncated)
      report_mismatch("out_truncated", got.out_truncated, want.out_truncated);
  endtask

  // result side: checks each item taken, idles at random, holds off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(res_item);
      if (hold_seen_id != hold_req_id) begin
        hold_seen_id = hold_req_id;
        hold_left    = hold_req_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input src_item_t it);
    if ($urandom_range(99) < snd_idle_pct) begin
      if (push) push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    push     <= 1'b1;
    src_item <= it;
    do @(posedge clk); while (full !== 1'b0);
    sanitize_item(it);
    n_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(item_of(b, 1'b1, 1'b0));
  endtask

  task automatic send_bytes(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_all_results();
    if (push) push <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_now = v;
  endtask

  task automatic set_idle(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct <= rcv;
  endtask

  task automatic test_legal_chars();
    logic [7:0] s[$];
    s = {8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_bytes(s);
    send_item(item_of(8'h00, 1'b0, 1'b0));   // empty item, not last
    send_item(item_of(8'h7F, 1'b1, 1'b1));
    wait_all_results();
  endtask

  task automatic test_rejected_forms();
    logic [7:0] s[$];
    // overlong, surrogate, above U+10FFFF, bad lead, stray continuation, interrupted
    s = {8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
         8'hFF, 8'h80, 8'hE2, 8'h41};
    send_bytes(s);
    send_item(item_of(8'hC3, 1'b1, 1'b1));   // lead still open at end of string
    wait_all_results();
  endtask

  task automatic test_truncation();
    logic [7:0] s[$];
    write_capacity(16'd0);                   // behaves as capacity one
    send_item(item_of(8'h41, 1'b1, 1'b1));
    wait_all_results();
    write_capacity(16'd4);
    s = {8'h41, 8'hE2, 8'h82, 8'hAC, 8'h42, 8'hC3};   // bytes after the stop are dropped
    send_bytes(s);
    send_item(item_of(8'h00, 1'b0, 1'b1));
    s = {8'h41, 8'h42, 8'hC3};               // end flush does not fit
    send_bytes(s);
    send_item(item_of(8'h00, 1'b0, 1'b1));
    wait_all_results();
  endtask

  task automatic test_capacity_change();
    write_capacity(16'hFFFF);
    send_byte(8'h41);
    send_byte(8'h42);
    wait_all_results();
    write_capacity(16'd3);                   // room already used up
    send_item(item_of(8'h43, 1'b1, 1'b1));
    wait_all_results();
    write_capacity(CAP_RESET);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    wait_all_results();
    write_capacity(16'hFFFF);
    hold_req_len <= 300;
    hold_req_id  <= hold_req_id + 1;
    repeat (30) send_byte(8'hFF);
    send_item(item_of(8'h00, 1'b0, 1'b1));
    wait_all_results();
  endtask

  task automatic send_random_char();
    int r, k;
    logic [7:0] lead;
    r = $urandom_range(99);
    if (r < 40) begin
      send_byte(8'($urandom_range(127)));
    end else if (r < 55) begin
      send_byte(8'($urandom_range(8'hDF, 8'hC2)));
      send_byte(cont_byte());
    end else if (r < 68) begin
      lead = 8'($urandom_range(8'hEF, 8'hE0));
      send_byte(lead);
      if (lead == 8'hE0) send_byte(8'($urandom_range(8'hBF, 8'hA0)));
      else if (lead == 8'hED) send_byte(8'($urandom_range(8'h9F, 8'h80)));
      else send_byte(cont_byte());
      send_byte(cont_byte());
    end else if (r < 78) begin
      lead = 8'($urandom_range(8'hF4, 8'hF0));
      send_byte(lead);
      if (lead == 8'hF0) send_byte(8'($urandom_range(8'hBF, 8'h90)));
      else if (lead == 8'hF4) send_byte(8'($urandom_range(8'h8F, 8'h80)));
      else send_byte(cont_byte());
      send_byte(cont_byte());
      send_byte(cont_byte());
    end else if (r < 85) begin
      // well-shaped but rejected
      case ($urandom_range(3))
        0: begin
          send_byte(8'($urandom_range(8'hC1, 8'hC0)));
          send_byte(cont_byte());
        end
        1: begin
          send_byte(8'hE0);
          send_byte(8'($urandom_range(8'h9F, 8'h80)));
          send_byte(cont_byte());
        end
        2: begin
          send_byte(8'hED);
          send_byte(8'($urandom_range(8'hBF, 8'hA0)));
          send_byte(cont_byte());
        end
        default: begin
          lead = 8'($urandom_range(8'hF7, 8'hF4));
          send_byte(lead);
          if (lead == 8'hF4) send_byte(8'($urandom_range(8'hBF, 8'h90)));
          else send_byte(cont_byte());
          send_byte(cont_byte());
          send_byte(cont_byte());
        end
      endcase
    end else if (r < 91) begin
      // lead cut short
      k = $urandom_range(4, 2);
      if (k == 2) send_byte(8'($urandom_range(8'hDF, 8'hC2)));
      else if (k == 3) send_byte(8'($urandom_range(8'hEC, 8'hE1)));
      else send_byte(8'($urandom_range(8'hF3, 8'hF1)));
      repeat ($urandom_range(k - 2, 0)) send_byte(cont_byte());
    end else if (r < 97) begin
      send_byte(8'($urandom()));
    end else begin
      send_item(item_of(8'($urandom()), 1'b0, 1'b0));
    end
  endtask

  task automatic test_random_strings(input int n_items);
    int stop_at;
    logic [15:0] cap;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0:       cap = 16'd1;
          1:       cap = 16'hFFFF;
          2:       cap = 16'($urandom_range(12, 2));
          3:       cap = 16'($urandom_range(60, 13));
          default: cap = CAP_RESET;
        endcase
        wait_all_results();
        write_capacity(cap);
      end
      repeat ($urandom_range(10, 1)) send_random_char();
      if ($urandom_range(1) == 1) send_item(item_of(8'($urandom()), 1'b1, 1'b1));
      else send_item(item_of(8'($urandom()), 1'b0, 1'b1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_idle(7, 51);
    test_legal_chars();
    test_rejected_forms();
    test_truncation();
    test_capacity_change();
    test_random_strings(80);
    set_idle(51, 7);
    test_random_strings(80);
    set_idle(0, 0);
    test_backpressure();
    test_random_strings(80);
    wait_all_results();
    if (n_mismatch == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
